// File: rtl/cusp_pkg.sv
// Shared types and constants for the streaming CoAP URL parser.
// Holds the parser state record, the result record, the phase and status codes.
// No dependencies; imported by cusp_core and coap_url_stream_parser.
package cusp_pkg;

  // Parser phases (plain state vector with localparam codes).
  localparam logic [2:0] PH_SCHEME     = 3'd0;
  localparam logic [2:0] PH_HOST_OPEN  = 3'd1;
  localparam logic [2:0] PH_HOST       = 3'd2;
  localparam logic [2:0] PH_AFTER_HOST = 3'd3;
  localparam logic [2:0] PH_PORT       = 3'd4;
  localparam logic [2:0] PH_SEG        = 3'd5;
  localparam logic [2:0] PH_DRAIN      = 3'd6;

  // Status codes reported with the final result of a URL.
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_SCHEME = 3'd1;
  localparam logic [2:0] ST_HOST   = 3'd2;
  localparam logic [2:0] ST_PORT   = 3'd3;
  localparam logic [2:0] ST_SEG    = 3'd4;
  localparam logic [2:0] ST_PARTS  = 3'd5;
  localparam logic [2:0] ST_LONG   = 3'd6;

  // Protocol codes.
  localparam logic [1:0] PROTO_COAP    = 2'd0;
  localparam logic [1:0] PROTO_COAPS   = 2'd1;
  localparam logic [1:0] PROTO_UNKNOWN = 2'd2;

  // Segment types.
  localparam logic SEG_PATH  = 1'b0;
  localparam logic SEG_QUERY = 1'b1;

  // Longest host text accepted between the brackets.
  localparam logic [5:0] HOST_MAX = 6'd39;

  typedef struct packed {
    logic [2:0]  phase;
    logic [3:0]  match_index;
    logic [1:0]  proto;
    logic [15:0] port_acc;
    logic        port_set;
    logic [5:0]  host_len;
    logic        cur_type;
    logic [7:0]  cur_len;
    logic [7:0]  cur_start;
    logic [7:0]  byte_pos;
    logic [3:0]  parts;
  } cusp_state_t;

  typedef struct packed {
    logic        has_res;
    logic        seg_valid;
    logic        seg_type;
    logic [7:0]  seg_start;
    logic [7:0]  seg_len;
    logic        done_res;
    logic [2:0]  status;
    logic [1:0]  protocol;
    logic [15:0] port_out;
    logic [3:0]  part_count;
  } cusp_res_t;

  // State at reset and at the start of every new URL.
  localparam cusp_state_t CUSP_IDLE = '{
    phase:       PH_SCHEME,
    match_index: 4'd0,
    proto:       PROTO_UNKNOWN,
    port_acc:    16'd0,
    port_set:    1'b0,
    host_len:    6'd0,
    cur_type:    SEG_PATH,
    cur_len:     8'd0,
    cur_start:   8'd0,
    byte_pos:    8'd0,
    parts:       4'd0
  };

endpackage

// File: rtl/cusp_core.sv
// Per-byte step logic of the CoAP URL parser: next state and result for one byte.
// Purely combinational; depends on cusp_pkg.
module cusp_core #(
  parameter int MAX_PARTS   = 8,
  parameter int MAX_URL_LEN = 255
) (
  input  cusp_pkg::cusp_state_t st_i,
  input  logic [7:0]            char_i,
  input  logic                  last_i,
  input  logic [15:0]           default_port_i,
  output cusp_pkg::cusp_state_t st_o,
  output cusp_pkg::cusp_res_t   res_o
);
  import cusp_pkg::*;

  localparam logic [3:0] MaxPartsC = 4'(MAX_PARTS);
  localparam logic [7:0] MaxLenC   = 8'(MAX_URL_LEN);

  // Expected prefix byte at a given match position.
  function automatic logic [7:0] want_char(input logic [1:0] proto, input logic [2:0] idx);
    logic [7:0] w;
    unique case (idx)
      3'd0: w = "c";
      3'd1: w = "o";
      3'd2: w = "a";
      3'd3: w = "p";
      3'd4: w = (proto == PROTO_COAPS) ? "s" : ":";
      3'd5: w = (proto == PROTO_COAPS) ? ":" : "/";
      default: w = "/";
    endcase
    return w;
  endfunction

  always_comb begin
    cusp_state_t nxt;
    logic [2:0]  err;
    logic        seg;
    logic        was_delim;
    logic        open_req;
    logic        prev_query;
    logic        ok;
    logic [3:0]  mi;
    logic [15:0] nv;
    logic        is_delim;
    logic        done;

    nxt        = st_i;
    err        = ST_OK;
    seg        = 1'b0;
    was_delim  = 1'b0;
    open_req   = 1'b0;
    ok         = 1'b1;
    mi         = 4'd0;
    nv         = 16'd0;
    done       = 1'b0;
    res_o      = '0;
    is_delim   = (char_i == "/") || (char_i == "?") || (char_i == "&");
    prev_query = (st_i.phase == PH_SEG) && (st_i.cur_type == SEG_QUERY);

    if (st_i.phase == PH_DRAIN) begin
      if (last_i) begin
        nxt = CUSP_IDLE;
      end
    end else begin
      if (st_i.byte_pos >= MaxLenC) begin
        err = ST_LONG;
      end else begin
        unique case (st_i.phase)
          PH_SCHEME: begin
            if (st_i.match_index == 4'd0 && char_i == "[") begin
              nxt.phase = PH_HOST;
            end else if (st_i.match_index == 4'd0 && char_i != "c") begin
              err = ST_HOST;
            end else begin
              if (st_i.match_index == 4'd4) begin
                if (char_i == ":") begin
                  nxt.proto = PROTO_COAP;
                end else if (char_i == "s") begin
                  nxt.proto = PROTO_COAPS;
                end else begin
                  nxt.proto = PROTO_UNKNOWN;
                  ok = 1'b0;
                end
              end else if (char_i != want_char(st_i.proto, st_i.match_index[2:0])) begin
                nxt.proto = PROTO_UNKNOWN;
                ok = 1'b0;
              end
              if (ok) begin
                mi = st_i.match_index + 4'd1;
                nxt.match_index = mi;
                if (mi >= 4'd5 && mi == ((nxt.proto == PROTO_COAPS) ? 4'd8 : 4'd7)) begin
                  nxt.phase = PH_HOST_OPEN;
                end
              end else begin
                err = ST_SCHEME;
              end
            end
          end
          PH_HOST_OPEN: begin
            if (char_i == "[") nxt.phase = PH_HOST;
            else err = ST_HOST;
          end
          PH_HOST: begin
            if (char_i == "]") nxt.phase = PH_AFTER_HOST;
            else if (st_i.host_len >= HOST_MAX) err = ST_HOST;
            else nxt.host_len = st_i.host_len + 6'd1;
          end
          PH_AFTER_HOST: begin
            if (char_i == ":") begin
              nxt.phase = PH_PORT;
            end else if (is_delim) begin
              was_delim = 1'b1;
              open_req  = 1'b1;
            end else begin
              err = ST_SEG;
            end
          end
          PH_PORT: begin
            if (char_i >= "0" && char_i <= "9") begin
              // acc * 10 as two shifts, kept to 16 bits like the wire format
              nv = (st_i.port_acc << 3) + (st_i.port_acc << 1) + {8'd0, char_i - 8'h30};
              if (nv > st_i.port_acc) nxt.port_acc = nv;
              else err = ST_PORT;
            end else if (char_i == "/") begin
              nxt.port_set = 1'b1;
              was_delim    = 1'b1;
              open_req     = 1'b1;
            end else begin
              err = ST_PORT;
            end
          end
          default: begin
            if (is_delim) begin
              was_delim = 1'b1;
              if ((char_i == "&" && st_i.cur_type == SEG_PATH) ||
                  (char_i == "/" && st_i.cur_type == SEG_QUERY)) begin
                err = ST_SEG;
              end else begin
                seg      = 1'b1;
                open_req = 1'b1;
              end
            end else begin
              nxt.cur_len = st_i.cur_len + 8'd1;
            end
          end
        endcase

        // Opening a new segment at the delimiter just seen.
        if (open_req) begin
          if (char_i == "&" && !prev_query) begin
            err = ST_SEG;
          end else if (st_i.parts >= MaxPartsC) begin
            err = ST_PARTS;
          end else begin
            nxt.parts     = st_i.parts + 4'd1;
            nxt.cur_type  = (char_i == "/") ? SEG_PATH : SEG_QUERY;
            nxt.cur_len   = 8'd0;
            nxt.cur_start = st_i.byte_pos + 8'd1;
            nxt.phase     = PH_SEG;
          end
        end
      end

      if (st_i.byte_pos != 8'hFF) begin
        nxt.byte_pos = st_i.byte_pos + 8'd1;
      end

      // End of the URL: check that it stopped in a place where it may stop.
      if (err == ST_OK && last_i) begin
        if (nxt.phase == PH_PORT) begin
          err = ST_PORT;
        end else if (nxt.phase == PH_SCHEME) begin
          err = (nxt.match_index != 4'd0) ? ST_SCHEME : ST_HOST;
        end else if (nxt.phase == PH_HOST_OPEN || nxt.phase == PH_HOST) begin
          err = ST_HOST;
        end else if (nxt.phase == PH_SEG && !was_delim) begin
          seg = 1'b1;
        end
      end

      done = (err != ST_OK) || last_i;

      res_o.has_res    = seg || done;
      res_o.seg_valid  = seg;
      res_o.part_count = nxt.parts;
      if (seg) begin
        res_o.seg_type  = st_i.cur_type;
        res_o.seg_start = st_i.cur_start;
        res_o.seg_len   = (st_i.phase == PH_SEG && !was_delim) ? nxt.cur_len : st_i.cur_len;
      end
      if (done) begin
        res_o.done_res = 1'b1;
        res_o.status   = err;
        res_o.protocol = nxt.proto;
        res_o.port_out = nxt.port_set ? nxt.port_acc : default_port_i;
        if (last_i) nxt = CUSP_IDLE;
        else nxt.phase = PH_DRAIN;
      end
    end

    st_o = nxt;
  end

endmodule

// File: rtl/coap_url_stream_parser.sv
// Top level of the streaming CoAP URL parser: handshakes, state and result registers.
// Depends on cusp_pkg and cusp_core.
//
// Usage. The URL arrives one byte per transaction on the in_ channel, the byte in
// in_tdata and in_tlast high on its final byte. The block strips an optional coap://
// or coaps:// prefix, checks a bracketed host and an optional decimal port, and cuts
// the rest into path and query segments. Each completed segment gives one result
// transaction on the out_ channel (out_tuser[0] high); the final byte of a URL, or
// the first error, gives a result with out_tlast high carrying status, protocol,
// port and part count. Both may share one transaction. Bytes that cause no result
// give none; after an error the block swallows bytes up to and including in_tlast.
// The user writes the default port (cfg_wen/cfg_wdata) only when idle; not enforced.
//
// A result appears on out_tvalid in the cycle after the byte that caused it is
// accepted, and one byte is taken in every cycle unless in_tready is held low.
// The whole step for a byte (compare, multiply by ten, segment bookkeeping) is
// combinational between the parser state registers and the output register.
// Stalls: the output register lets a new byte in while its result is taken in the
// same cycle; while a result waits with out_tready low, in_tready is held low.
// Reset (synchronous, rst_n low) empties the output register, returns the parser to
// the start of a URL and sets the default port to 5683.
module coap_url_stream_parser #(
  parameter int MAX_PARTS   = 8,
  parameter int MAX_URL_LEN = 255
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel. in_tdata: [7:0] char_in. in_tlast: last.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tlast,
  // Result channel.
  // out_tdata: [7:0] seg_start, [15:8] seg_len, [18:16] status, [20:19] protocol,
  //            [36:21] port_out, [40:37] part_count, [47:41] zero.
  // out_tuser: [0] seg_valid, [1] seg_type. out_tlast: done_res.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,
  output logic [1:0]  out_tuser,
  output logic        out_tlast,
  // Configuration: default port.
  input  logic        cfg_wen,
  input  logic [15:0] cfg_wdata
);
  import cusp_pkg::*;

  cusp_state_t st_r;
  cusp_state_t st_nxt;
  cusp_res_t   res;
  logic [15:0] default_port_r;
  logic        out_valid_r;
  logic [47:0] out_data_r;
  logic [1:0]  out_user_r;
  logic        out_last_r;
  logic        in_acc;

  cusp_core #(
    .MAX_PARTS  (MAX_PARTS),
    .MAX_URL_LEN(MAX_URL_LEN)
  ) u_core (
    .st_i          (st_r),
    .char_i        (in_tdata),
    .last_i        (in_tlast),
    .default_port_i(default_port_r),
    .st_o          (st_nxt),
    .res_o         (res)
  );

  // The output register either is empty or is being emptied in this cycle.
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r           <= CUSP_IDLE;
      default_port_r <= 16'd5683;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_wen) begin
        default_port_r <= cfg_wdata;
      end
      if (in_acc) begin
        st_r <= st_nxt;
      end
      if (in_acc && res.has_res) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload; no reset needed as out_valid_r qualifies it.
  always_ff @(posedge clk) begin
    if (in_acc && res.has_res) begin
      out_data_r <= {7'd0, res.part_count, res.port_out, res.protocol, res.status,
                     res.seg_len, res.seg_start};
      out_user_r <= {res.seg_type, res.seg_valid};
      out_last_r <= res.done_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule

// File: rtl/cusp_checker.sv
// Port-level checks for the CoAP URL parser, bound to the top level.
// Depends on nothing but the top level's port names.
module cusp_port_props (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  // Reset leaves no result pending.
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

  // A stalled result holds its payload.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
      && $stable(out_tlast))
    else $error("stalled result changed");

  // Every result carries a segment, a final report or both.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser[0] || out_tlast)
    else $error("empty result transaction");

  // Segment fields are zero when no segment is reported.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[15:0] == 16'd0 && !out_tuser[1])
    else $error("segment fields set without a segment");

  // Status, protocol and port fields are zero on a result that does not end the URL.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[36:16] == 21'd0)
    else $error("status fields set before the end of the URL");

endmodule

bind coap_url_stream_parser cusp_port_props u_cusp_port_props (.*);
